### rtl/ffpa_pkg.sv
// shared types, field widths and codes for the first-fit partition allocator
// no dependencies; imported by ffpa_ctrl, ffpa_dp and the top level
package ffpa_pkg;

    // default sizing
    localparam int MAX_ENTRIES_DEF = 64;
    localparam int ADDR_BITS_DEF   = 16;

    // field widths of the transactions
    localparam int OP_W     = 2;
    localparam int SIZE_W   = 16;
    localparam int PID_W    = 16;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int START_W  = 16;
    localparam int END_W    = 17;
    localparam int COUNT_W  = 7;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADSIZE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADINDEX = 3'd4;

    // table pointer commands
    typedef logic [2:0] ptr_op_t;
    localparam ptr_op_t PTR_HOLD  = 3'd0;
    localparam ptr_op_t PTR_ZERO  = 3'd1;
    localparam ptr_op_t PTR_INC   = 3'd2;
    localparam ptr_op_t PTR_DEC   = 3'd3;
    localparam ptr_op_t PTR_LAST  = 3'd4;
    localparam ptr_op_t PTR_INDEX = 3'd5;

    // table write commands
    typedef logic [2:0] wr_op_t;
    localparam wr_op_t WR_NONE   = 3'd0;
    localparam wr_op_t WR_APPEND = 3'd1;
    localparam wr_op_t WR_SHIFT  = 3'd2;
    localparam wr_op_t WR_SPLIT  = 3'd3;
    localparam wr_op_t WR_ALLOC  = 3'd4;

    // pending result load commands
    typedef logic [2:0] res_op_t;
    localparam res_op_t RES_NONE   = 3'd0;
    localparam res_op_t RES_REJECT = 3'd1;
    localparam res_op_t RES_APPEND = 3'd2;
    localparam res_op_t RES_READ   = 3'd3;
    localparam res_op_t RES_ALLOC  = 3'd4;

    // input transaction
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [SIZE_W-1:0]  size_value;
        logic [PID_W-1:0]   process_id;
        logic [INDEX_W-1:0] entry_index;
    } req_t;

    // result transaction
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [START_W-1:0]  start_addr;
        logic [END_W-1:0]    end_addr;
        logic [SIZE_W-1:0]   block_size;
        logic                in_use;
        logic [PID_W-1:0]    owner;
        logic [COUNT_W-1:0]  entry_count;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic                capture;
        ptr_op_t             ptr_op;
        wr_op_t              wr_op;
        res_op_t             res_op;
        logic [STATUS_W-1:0] rej_status;
        logic                hit_load;
        logic                out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            size_zero;
        logic            table_full;
        logic            table_empty;
        logic            space_over;
        logic            index_bad;
        logic            fit;
        logic            rest_zero;
        logic            scan_last;
        logic            shift_done;
        logic            out_free;
    } dp_stat_t;

endpackage

### rtl/ffpa_dp.sv
// datapath: partition table memory, counters, scan pointer and result register
// depends on ffpa_pkg; driven by ffpa_ctrl through dp_cmd_t
module ffpa_dp
    import ffpa_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  req_t     req,
    input  dp_cmd_t  cmd,
    output dp_stat_t stat,
    output rsp_t     rsp,
    output logic     rsp_valid,
    input  logic     rsp_ready
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int SW = ((ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W) + 2;
    localparam int EW = ADDR_BITS + SIZE_W + 1 + PID_W;

    // entry layout: {start, size, in_use, owner}
    localparam int OWN_LO   = 0;
    localparam int USE_BIT  = PID_W;
    localparam int SIZE_LO  = PID_W + 1;
    localparam int START_LO = PID_W + 1 + SIZE_W;

    logic [EW-1:0]        mem [MAX_ENTRIES];

    req_t                 item_reg;
    logic [CW-1:0]        used_reg;
    logic [ADDR_BITS:0]   top_reg;
    logic [IW-1:0]        ptr_reg;
    logic [IW-1:0]        ptr_next;
    logic [EW-1:0]        rd_data_reg;
    logic [IW-1:0]        hit_slot_reg;
    logic [ADDR_BITS-1:0] hit_start_reg;
    logic [SIZE_W-1:0]    hit_size_reg;
    logic [STATUS_W-1:0]  res_status_reg;
    logic [IW-1:0]        res_slot_reg;
    logic [EW-1:0]        res_entry_reg;
    rsp_t                 rsp_reg;
    logic                 rsp_valid_reg;

    logic [ADDR_BITS-1:0] rd_start;
    logic [SIZE_W-1:0]    rd_size;
    logic                 rd_use;
    logic [SW-1:0]        top_sum;
    logic [EW-1:0]        app_entry;
    logic [EW-1:0]        split_entry;
    logic [EW-1:0]        alloc_entry;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [EW-1:0]        wr_data;
    logic [ADDR_BITS-1:0] res_start;
    logic [SIZE_W-1:0]    res_size;
    logic                 res_use;
    logic [PID_W-1:0]     res_owner;

    // fields of the entry under the pointer
    assign rd_start = rd_data_reg[START_LO +: ADDR_BITS];
    assign rd_size  = rd_data_reg[SIZE_LO +: SIZE_W];
    assign rd_use   = rd_data_reg[USE_BIT];

    assign top_sum = SW'(top_reg) + SW'(item_reg.size_value);

    // candidate entries for table writes
    assign app_entry   = {ADDR_BITS'(top_reg), item_reg.size_value, 1'b0, {PID_W{1'b0}}};
    assign split_entry = {ADDR_BITS'(hit_start_reg + ADDR_BITS'(item_reg.size_value)),
                          SIZE_W'(hit_size_reg - item_reg.size_value), 1'b0, {PID_W{1'b0}}};
    assign alloc_entry = {hit_start_reg, item_reg.size_value, 1'b1, item_reg.process_id};

    // status toward the controller
    always_comb
    begin
        stat.op          = item_reg.op;
        stat.size_zero   = (item_reg.size_value == '0);
        stat.table_full  = (used_reg == CW'(MAX_ENTRIES));
        stat.table_empty = (used_reg == '0);
        stat.space_over  = (top_sum > (SW'(1) << ADDR_BITS));
        stat.index_bad   = (XW'(item_reg.entry_index) >= XW'(used_reg));
        stat.fit         = !rd_use && (rd_size >= item_reg.size_value);
        stat.rest_zero   = (rd_size == item_reg.size_value);
        stat.scan_last   = ((CW'(ptr_reg) + CW'(1)) == used_reg);
        stat.shift_done  = (ptr_reg == (hit_slot_reg + IW'(1)));
        stat.out_free    = !rsp_valid_reg || rsp_ready;
    end

    // next pointer, also the read address
    always_comb
    begin
        unique case (cmd.ptr_op)
            PTR_HOLD:  ptr_next = ptr_reg;
            PTR_ZERO:  ptr_next = '0;
            PTR_INC:   ptr_next = ptr_reg + IW'(1);
            PTR_DEC:   ptr_next = ptr_reg - IW'(1);
            PTR_LAST:  ptr_next = IW'(used_reg - CW'(1));
            PTR_INDEX: ptr_next = IW'(item_reg.entry_index);
            default:   ptr_next = ptr_reg;
        endcase
    end

    // write port select
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_data = rd_data_reg;
        unique case (cmd.wr_op)
            WR_NONE:
            begin
                wr_en = 1'b0;
            end
            WR_APPEND:
            begin
                wr_en   = 1'b1;
                wr_addr = IW'(used_reg);
                wr_data = app_entry;
            end
            WR_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg + IW'(1);
                wr_data = rd_data_reg;
            end
            WR_SPLIT:
            begin
                wr_en   = 1'b1;
                wr_addr = hit_slot_reg + IW'(1);
                wr_data = split_entry;
            end
            WR_ALLOC:
            begin
                wr_en   = 1'b1;
                wr_addr = hit_slot_reg;
                wr_data = alloc_entry;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // partition table, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[ptr_next];
    end

    // pointer and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            top_reg  <= '0;
            ptr_reg  <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            if (cmd.wr_op == WR_APPEND || cmd.wr_op == WR_SPLIT)
            begin
                used_reg <= used_reg + CW'(1);
            end
            if (cmd.wr_op == WR_APPEND)
            begin
                top_reg <= (ADDR_BITS + 1)'(top_sum);
            end
        end
    end

    // item capture, hit record and pending result
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req;
        end
        if (cmd.hit_load)
        begin
            hit_slot_reg  <= ptr_reg;
            hit_start_reg <= rd_start;
            hit_size_reg  <= rd_size;
        end
        unique case (cmd.res_op)
            RES_NONE:
            begin
                res_status_reg <= res_status_reg;
            end
            RES_REJECT:
            begin
                res_status_reg <= cmd.rej_status;
                res_slot_reg   <= '0;
                res_entry_reg  <= '0;
            end
            RES_APPEND:
            begin
                res_status_reg <= ST_OK;
                res_slot_reg   <= IW'(used_reg);
                res_entry_reg  <= app_entry;
            end
            RES_READ:
            begin
                res_status_reg <= ST_OK;
                res_slot_reg   <= ptr_reg;
                res_entry_reg  <= rd_data_reg;
            end
            RES_ALLOC:
            begin
                res_status_reg <= ST_OK;
                res_slot_reg   <= hit_slot_reg;
                res_entry_reg  <= alloc_entry;
            end
            default:
            begin
                res_status_reg <= res_status_reg;
            end
        endcase
    end

    assign res_start = res_entry_reg[START_LO +: ADDR_BITS];
    assign res_size  = res_entry_reg[SIZE_LO +: SIZE_W];
    assign res_use   = res_entry_reg[USE_BIT];
    assign res_owner = res_entry_reg[OWN_LO +: PID_W];

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_reg.status      <= res_status_reg;
            rsp_reg.slot        <= SLOT_W'(res_slot_reg);
            rsp_reg.start_addr  <= START_W'(res_start);
            rsp_reg.end_addr    <= END_W'(res_start) + END_W'(res_size);
            rsp_reg.block_size  <= res_size;
            rsp_reg.in_use      <= res_use;
            rsp_reg.owner       <= res_use ? res_owner : '0;
            rsp_reg.entry_count <= COUNT_W'(used_reg);
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

### rtl/ffpa_ctrl.sv
// controller: state machine that sequences decode, scan, shift, insert, allocate, read-out and response
// depends on ffpa_pkg; drives ffpa_dp through dp_cmd_t
module ffpa_ctrl
    import ffpa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_INSERT = 3'd4;
    localparam logic [2:0] S_ALLOC  = 3'd5;
    localparam logic [2:0] S_RDOUT  = 3'd6;
    localparam logic [2:0] S_RESP   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        req_ready      = 1'b0;
        cmd.capture    = 1'b0;
        cmd.ptr_op     = PTR_HOLD;
        cmd.wr_op      = WR_NONE;
        cmd.res_op     = RES_NONE;
        cmd.rej_status = ST_OK;
        cmd.hit_load   = 1'b0;
        cmd.out_load   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next = S_RESP;
                unique case (stat.op)
                    OP_ADD:
                    begin
                        priority if (stat.size_zero)
                        begin
                            cmd.res_op     = RES_REJECT;
                            cmd.rej_status = ST_BADSIZE;
                        end
                        else if (stat.table_full)
                        begin
                            cmd.res_op     = RES_REJECT;
                            cmd.rej_status = ST_FULL;
                        end
                        else if (stat.space_over)
                        begin
                            cmd.res_op     = RES_REJECT;
                            cmd.rej_status = ST_NOFIT;
                        end
                        else
                        begin
                            cmd.wr_op  = WR_APPEND;
                            cmd.res_op = RES_APPEND;
                        end
                    end
                    OP_ALLOC:
                    begin
                        priority if (stat.size_zero)
                        begin
                            cmd.res_op     = RES_REJECT;
                            cmd.rej_status = ST_BADSIZE;
                        end
                        else if (stat.table_empty)
                        begin
                            cmd.res_op     = RES_REJECT;
                            cmd.rej_status = ST_NOFIT;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_ZERO;
                            state_next = S_SCAN;
                        end
                    end
                    OP_READ:
                    begin
                        if (stat.index_bad)
                        begin
                            cmd.res_op     = RES_REJECT;
                            cmd.rej_status = ST_BADINDEX;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_INDEX;
                            state_next = S_RDOUT;
                        end
                    end
                    default:
                    begin
                        cmd.res_op     = RES_REJECT;
                        cmd.rej_status = ST_BADINDEX;
                    end
                endcase
            end

            // one entry checked per cycle, first free one that fits wins
            S_SCAN:
            begin
                priority if (stat.fit)
                begin
                    cmd.hit_load = 1'b1;
                    priority if (stat.rest_zero)
                    begin
                        state_next = S_ALLOC;
                    end
                    else if (stat.table_full)
                    begin
                        cmd.res_op     = RES_REJECT;
                        cmd.rej_status = ST_FULL;
                        state_next     = S_RESP;
                    end
                    else if (stat.scan_last)
                    begin
                        state_next = S_INSERT;
                    end
                    else
                    begin
                        cmd.ptr_op = PTR_LAST;
                        state_next = S_SHIFT;
                    end
                end
                else if (stat.scan_last)
                begin
                    cmd.res_op     = RES_REJECT;
                    cmd.rej_status = ST_NOFIT;
                    state_next     = S_RESP;
                end
                else
                begin
                    cmd.ptr_op = PTR_INC;
                end
            end

            // move the tail down one slot, last entry first
            S_SHIFT:
            begin
                cmd.wr_op = WR_SHIFT;
                if (stat.shift_done)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    cmd.ptr_op = PTR_DEC;
                end
            end

            S_INSERT:
            begin
                cmd.wr_op  = WR_SPLIT;
                state_next = S_ALLOC;
            end

            S_ALLOC:
            begin
                cmd.wr_op  = WR_ALLOC;
                cmd.res_op = RES_ALLOC;
                state_next = S_RESP;
            end

            S_RDOUT:
            begin
                cmd.res_op = RES_READ;
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/first_fit_partition_allocator_top.sv
// sequence per transaction: accept, decode, then the result; add and early rejects
// go straight to the result, read passes through a read-out state, and allocate scans
// entries in order, on a split moves the tail down and inserts the remainder, then allocates
// one transaction in flight, taken only in the idle state; its length is set by the
// entry-by-entry scan and tail shift; next request taken while a result waits
// async active-low reset empties the table count and address top; no clearing pass
module first_fit_partition_allocator_top
    import ffpa_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ffpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ffpa_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready)
    );

    // rejected transactions carry an empty entry
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |->
            (rsp.slot == '0) && (rsp.block_size == '0) && !rsp.in_use && (rsp.owner == '0))
    else $error("rejected result carries entry data");

    // every valid entry has a nonzero size
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_OK) |-> (rsp.block_size != '0))
    else $error("ok result with zero block size");

    // a free entry reports no owner
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.in_use |-> (rsp.owner == '0))
    else $error("free entry reports an owner");

    // after a request is accepted, the block is busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one in progress");

endmodule
